### rtl/chtg_pkg.sv
// Shared constants, codes and structures of the core hotplug governor.
package chtg_pkg;

	localparam int NUM_CORES_DEF = 8;
	localparam int SCAN_MAX      = 8;
	localparam int SCAN_W        = 3;
	localparam int CORE_W        = 3;
	localparam int TS_W          = 48;
	localparam int PROD_W        = 55;
	localparam int DIV_CW        = 6;
	localparam int LOAD_W        = 7;
	localparam int DLY_W         = 16;
	localparam int CFG_IW        = 1;
	localparam int LIMIT_SHIFT   = 2;

	localparam logic [DLY_W-1:0]  UP_DELAY_RST   = 16'd50;
	localparam logic [DLY_W-1:0]  DOWN_DELAY_RST = 16'd1000;
	localparam logic [LOAD_W-1:0] LOAD_FULL      = 7'd100;
	localparam logic [DIV_CW-1:0] DIV_LAST       = DIV_CW'(PROD_W - 1);

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_FREQ   = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_STOP   = 2'd3;

	localparam logic [1:0] GOV_IDLE     = 2'd0;
	localparam logic [1:0] GOV_DISABLED = 2'd1;
	localparam logic [1:0] GOV_ENABLED  = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_UP_DELAY   = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_DOWN_DELAY = 1'd1;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CORE_W-1:0] core_index;
		logic [TS_W-1:0]   idle_total_us;
		logic [TS_W-1:0]   stamp_us;
		logic              qualifying_change;
		logic              boost_active;
		logic [7:0]        online_mask;
	} item_t;

	typedef struct packed {
		logic [1:0]        governor_state;
		logic              sampling_on;
		logic [LOAD_W-1:0] sample_load;
		logic              wake_valid;
		logic [CORE_W-1:0] wake_core;
		logic              quiesce_valid;
		logic [CORE_W-1:0] quiesce_core;
		logic              check_pending;
	} res_t;

	typedef struct packed {
		logic load_item;
		logic calc;
		logic mul;
		logic div_step;
		logic wr_load;
		logic exec;
		logic scan_init;
		logic scan_adv;
		logic max_ev;
		logic min_ev;
		logic check_fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic sample_hit;
		logic need_scan;
		logic need_div;
		logic div_last;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/chtg_if.sv
// Valid/ready channel interfaces for input words and result words.
interface chtg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  core_index;
	logic [47:0] idle_total_us;
	logic [47:0] stamp_us;
	logic        qualifying_change;
	logic        boost_active;
	logic [7:0]  online_mask;

	modport source (output valid, mode, core_index, idle_total_us, stamp_us,
		qualifying_change, boost_active, online_mask, input ready);
	modport sink (input valid, mode, core_index, idle_total_us, stamp_us,
		qualifying_change, boost_active, online_mask, output ready);
endinterface

interface chtg_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] governor_state;
	logic       sampling_on;
	logic [6:0] sample_load;
	logic       wake_valid;
	logic [2:0] wake_core;
	logic       quiesce_valid;
	logic [2:0] quiesce_core;
	logic       check_pending;

	modport source (output valid, governor_state, sampling_on, sample_load, wake_valid,
		wake_core, quiesce_valid, quiesce_core, check_pending, input ready);
	modport sink (input valid, governor_state, sampling_on, sample_load, wake_valid,
		wake_core, quiesce_valid, quiesce_core, check_pending, output ready);
endinterface

### rtl/chtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/chtg_ctrl.sv
// Sequencing state machine of the governor.
module chtg_ctrl import chtg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'h001,
		S_DECODE = 12'h002,
		S_CALC   = 12'h004,
		S_MUL    = 12'h008,
		S_DIV    = 12'h010,
		S_LOAD   = 12'h020,
		S_MAXRD  = 12'h040,
		S_MAXEV  = 12'h080,
		S_MINRD  = 12'h100,
		S_MINEV  = 12'h200,
		S_FIN    = 12'h400,
		S_DONE   = 12'h800
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.sample_hit) begin
					state_d = S_CALC;
				end else if (sts.need_scan) begin
					cmd.scan_init = 1'b1;
					state_d       = S_MAXRD;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				if (sts.need_div) begin
					cmd.mul = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.wr_load = 1'b1;
				state_d     = S_DONE;
			end
			S_MAXRD: begin
				state_d = S_MAXEV;
			end
			S_MAXEV: begin
				cmd.max_ev   = 1'b1;
				cmd.scan_adv = 1'b1;
				state_d      = sts.scan_last ? S_MINRD : S_MAXRD;
			end
			S_MINRD: begin
				state_d = S_MINEV;
			end
			S_MINEV: begin
				cmd.min_ev   = 1'b1;
				cmd.scan_adv = 1'b1;
				state_d      = sts.scan_last ? S_FIN : S_MINRD;
			end
			S_FIN: begin
				cmd.check_fin = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/chtg_dp.sv
// Datapath: governor state, per-core stores, serial divider, load scan, result register.
module chtg_dp import chtg_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DLY_W-1:0]  cfg_wdata,
	input  item_t             in_item,
	input  cmd_t              cmd,
	output sts_t              sts,
	output res_t              res,
	output logic              res_valid,
	input  logic              res_ready
);

	localparam int CW         = $clog2(NUM_CORES);
	localparam int SCAN_CORES = (NUM_CORES < SCAN_MAX) ? NUM_CORES : SCAN_MAX;
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_CORES - 1);
	localparam int BASE_W     = 2 * TS_W;

	item_t             item_q;
	logic [1:0]        gov_q, gov_d;
	logic              samp_q, samp_d;
	logic              armed_q, armed_d;
	logic [DLY_W-1:0]  cnt_q, cnt_d;
	logic [DLY_W-1:0]  up_q, down_q;
	logic [NUM_CORES-1:0] pv_q, lv_q;
	logic              pv_rd_q, lv_rd_q;
	logic [TS_W-1:0]   dt_q, di_q, rem_q;
	logic [PROD_W-1:0] pq_q;
	logic [DIV_CW-1:0] dstep_q;
	logic [SCAN_W-1:0] scan_q;
	logic [LOAD_W-1:0] top_q, best_q, load_res_q;
	logic              skew_q, best_v_q;
	logic [SCAN_W-1:0] bc_q;
	logic              wv_q, wv_d, qv_q, qv_d;
	logic [CORE_W-1:0] wc_q, wc_d, qc_q, qc_d;
	res_t              res_q;
	logic              res_valid_q;

	logic [CW-1:0]     base_addr, load_raddr;
	logic [BASE_W-1:0] base_rdata;
	logic [LOAD_W-1:0] load_rdata, load_rd, new_load;
	logic [TS_W-1:0]   prev_idle, prev_stamp;
	logic [TS_W:0]     shifted;
	logic [TS_W+1:0]   diff;
	logic              ge;
	logic [PROD_W-1:0] prod;
	logic              wake_found;
	logic [CORE_W-1:0] wake_idx;
	logic              scan_online;

	assign base_addr  = CW'(item_q.core_index);
	assign load_raddr = CW'(scan_q);

	chtg_ram #(.WIDTH(BASE_W), .DEPTH(NUM_CORES)) u_base_ram (
		.clk   (clk),
		.we    (cmd.calc),
		.waddr (base_addr),
		.wdata ({item_q.idle_total_us, item_q.stamp_us}),
		.raddr (base_addr),
		.rdata (base_rdata)
	);

	chtg_ram #(.WIDTH(LOAD_W), .DEPTH(NUM_CORES)) u_load_ram (
		.clk   (clk),
		.we    (cmd.wr_load),
		.waddr (base_addr),
		.wdata (new_load),
		.raddr (load_raddr),
		.rdata (load_rdata)
	);

	// Entries never written read as zero.
	assign prev_idle  = pv_rd_q ? base_rdata[BASE_W-1:TS_W] : '0;
	assign prev_stamp = pv_rd_q ? base_rdata[TS_W-1:0] : '0;
	assign load_rd    = lv_rd_q ? load_rdata : '0;

	// One restoring divider step: shift in the next dividend bit, subtract if it fits.
	assign shifted = {rem_q, pq_q[PROD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dt_q};
	assign ge      = !diff[TS_W+1];

	assign prod = (PROD_W'(di_q) << 6) + (PROD_W'(di_q) << 5) + (PROD_W'(di_q) << 2);

	assign new_load = (pq_q > PROD_W'(LOAD_FULL)) ? '0 : LOAD_FULL - pq_q[LOAD_W-1:0];

	assign scan_online = item_q.online_mask[scan_q];

	always_comb begin
		wake_found = 1'b0;
		wake_idx   = '0;
		for (int c = 1; c < SCAN_CORES; c++) begin
			if (!wake_found && !item_q.online_mask[c]) begin
				wake_found = 1'b1;
				wake_idx   = CORE_W'(c);
			end
		end
	end

	assign sts.sample_hit = (item_q.mode == MODE_SAMPLE) &&
		(int'(item_q.core_index) < NUM_CORES);
	assign sts.need_scan  = (item_q.mode == MODE_TICK) && armed_q &&
		(cnt_q <= DLY_W'(1)) && (gov_q == GOV_DISABLED);
	assign sts.need_div   = samp_q && (dt_q != '0);
	assign sts.div_last   = (dstep_q == DIV_LAST);
	assign sts.scan_last  = (scan_q == SCAN_LAST);
	assign sts.out_free   = !res_valid_q || res_ready;

	always_comb begin
		gov_d   = gov_q;
		samp_d  = samp_q;
		armed_d = armed_q;
		cnt_d   = cnt_q;
		wv_d    = wv_q;
		wc_d    = wc_q;
		qv_d    = qv_q;
		qc_d    = qc_q;
		if (cmd.load_item) begin
			wv_d = 1'b0;
			wc_d = '0;
			qv_d = 1'b0;
			qc_d = '0;
		end
		if (cmd.exec) begin
			unique case (item_q.mode)
				MODE_SAMPLE: begin
				end
				MODE_FREQ: begin
					if (item_q.qualifying_change) begin
						unique case (gov_q)
							GOV_IDLE: begin
								gov_d = item_q.boost_active ? GOV_ENABLED : GOV_DISABLED;
								if (!armed_q) begin
									armed_d = 1'b1;
									cnt_d   = item_q.boost_active ? up_q : down_q;
								end
							end
							GOV_DISABLED: begin
								if (item_q.boost_active) begin
									gov_d = GOV_ENABLED;
									if (!armed_q) begin
										armed_d = 1'b1;
										cnt_d   = up_q;
									end
								end
							end
							GOV_ENABLED: begin
								if (!item_q.boost_active) begin
									gov_d = GOV_DISABLED;
									if (!armed_q) begin
										armed_d = 1'b1;
										cnt_d   = down_q;
									end
								end
							end
							default: begin
							end
						endcase
						samp_d = 1'b1;
					end
				end
				MODE_TICK: begin
					if (armed_q) begin
						if (cnt_q <= DLY_W'(1)) begin
							armed_d = 1'b0;
							cnt_d   = '0;
							if (gov_q == GOV_ENABLED) begin
								wv_d   = wake_found;
								wc_d   = wake_idx;
								samp_d = 1'b0;
							end
						end else begin
							cnt_d = cnt_q - DLY_W'(1);
						end
					end
				end
				MODE_STOP: begin
					gov_d   = GOV_IDLE;
					armed_d = 1'b0;
					cnt_d   = '0;
					samp_d  = 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.check_fin) begin
			if (skew_q) begin
				armed_d = 1'b0;
				cnt_d   = '0;
				qv_d    = best_v_q;
				qc_d    = CORE_W'(bc_q);
				samp_d  = 1'b0;
			end else begin
				armed_d = 1'b1;
				cnt_d   = down_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gov_q       <= GOV_DISABLED;
			samp_q      <= 1'b0;
			armed_q     <= 1'b0;
			cnt_q       <= '0;
			up_q        <= UP_DELAY_RST;
			down_q      <= DOWN_DELAY_RST;
			pv_q        <= '0;
			lv_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			gov_q   <= gov_d;
			samp_q  <= samp_d;
			armed_q <= armed_d;
			cnt_q   <= cnt_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_UP_DELAY:   up_q   <= cfg_wdata;
					CFG_DOWN_DELAY: down_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.calc) begin
				pv_q[base_addr] <= 1'b1;
			end
			if (cmd.wr_load) begin
				lv_q[base_addr] <= 1'b1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pv_rd_q <= pv_q[base_addr];
		lv_rd_q <= lv_q[load_raddr];
		wv_q    <= wv_d;
		wc_q    <= wc_d;
		qv_q    <= qv_d;
		qc_q    <= qc_d;
		if (cmd.load_item) begin
			item_q     <= in_item;
			load_res_q <= '0;
		end
		if (cmd.calc) begin
			dt_q <= item_q.stamp_us - prev_stamp;
			di_q <= item_q.idle_total_us - prev_idle;
		end
		if (cmd.mul) begin
			pq_q    <= prod;
			rem_q   <= '0;
			dstep_q <= '0;
		end else if (cmd.div_step) begin
			pq_q    <= {pq_q[PROD_W-2:0], ge};
			rem_q   <= ge ? diff[TS_W-1:0] : shifted[TS_W-1:0];
			dstep_q <= dstep_q + DIV_CW'(1);
		end
		if (cmd.wr_load) begin
			load_res_q <= new_load;
		end
		if (cmd.scan_init) begin
			scan_q   <= '0;
			top_q    <= '0;
			skew_q   <= 1'b0;
			best_v_q <= 1'b0;
			best_q   <= '0;
			bc_q     <= '0;
		end else begin
			if (cmd.scan_adv) begin
				scan_q <= (scan_q == SCAN_LAST) ? '0 : scan_q + SCAN_W'(1);
			end
			if (cmd.max_ev && scan_online && (load_rd > top_q)) begin
				top_q <= load_rd;
			end
			if (cmd.min_ev && scan_online) begin
				if (load_rd <= (top_q >> LIMIT_SHIFT)) begin
					skew_q <= 1'b1;
				end
				// Core 0 is never taken offline; ties keep the lower index.
				if ((scan_q != '0) && (!best_v_q || (load_rd < best_q))) begin
					best_v_q <= 1'b1;
					best_q   <= load_rd;
					bc_q     <= scan_q;
				end
			end
		end
		if (cmd.emit) begin
			res_q.governor_state <= gov_q;
			res_q.sampling_on    <= samp_q;
			res_q.sample_load    <= load_res_q;
			res_q.wake_valid     <= wv_q;
			res_q.wake_core      <= wc_q;
			res_q.quiesce_valid  <= qv_q;
			res_q.quiesce_core   <= qc_q;
			res_q.check_pending  <= armed_q;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

### rtl/core_hotplug_touch_governor_core.sv
// Top level of the core hotplug governor.
// Frequency-change, stop, plain tick and out-of-range sample words execute on decode; a sample
// for a stored core that computes no load passes the delta and multiply states, and one that
// computes a load also runs the 55-step serial divider. A tick that runs the check in disabled
// state makes two passes over the stored loads. The next word is accepted while a result waits
// in the output register. Reset is asynchronous and gives state disabled.
module core_hotplug_touch_governor_core import chtg_pkg::*; #(
	parameter int NUM_CORES = NUM_CORES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DLY_W-1:0]  cfg_wdata,
	chtg_in_if.sink           req,
	chtg_out_if.source        rsp
);

	item_t item;
	cmd_t  cmd;
	sts_t  sts;
	res_t  res;
	logic  rdy;
	logic  res_valid;

	assign item.mode              = req.mode;
	assign item.core_index        = req.core_index;
	assign item.idle_total_us     = req.idle_total_us;
	assign item.stamp_us          = req.stamp_us;
	assign item.qualifying_change = req.qualifying_change;
	assign item.boost_active      = req.boost_active;
	assign item.online_mask       = req.online_mask;
	assign req.ready              = rdy;

	chtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (rdy),
		.sts      (sts),
		.cmd      (cmd)
	);

	chtg_dp #(.NUM_CORES(NUM_CORES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_item   (item),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (rsp.ready)
	);

	assign rsp.valid          = res_valid;
	assign rsp.governor_state = res.governor_state;
	assign rsp.sampling_on    = res.sampling_on;
	assign rsp.sample_load    = res.sample_load;
	assign rsp.wake_valid     = res.wake_valid;
	assign rsp.wake_core      = res.wake_core;
	assign rsp.quiesce_valid  = res.quiesce_valid;
	assign rsp.quiesce_core   = res.quiesce_core;
	assign rsp.check_pending  = res.check_pending;

	// A new result is only loaded when the output register is empty or draining.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp.valid || rsp.ready))
		else $error("result loaded over an untaken word");

	a_quiesce_core: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.quiesce_valid) |-> (rsp.quiesce_core != '0))
		else $error("quiesce request names core 0");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.wake_valid && rsp.quiesce_valid))
		else $error("wake and quiesce in the same word");

	a_idle_no_check: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.governor_state == GOV_IDLE)) |-> !rsp.check_pending)
		else $error("check pending in idle state");

endmodule
